// File: design/grid_footprint_quantizer_defines.svh
// Assertion macros for the grid footprint quantizer.
`ifndef GRID_FOOTPRINT_QUANTIZER_DEFINES_SVH
`define GRID_FOOTPRINT_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define GFQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GFQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GFQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/gfq_pkg.sv
// Shared types and constants of the grid footprint quantizer.
package gfq_pkg;
  localparam int CoordBits = 32;
  localparam int CellBits  = 31;
  localparam int TolBits   = 17;
  localparam int MagBits   = CoordBits;
  localparam int QBits     = CoordBits;

  typedef enum logic [1:0] {
    CMD_CONTAIN = 2'd0,
    CMD_ALIGN   = 2'd1,
    CMD_POINT   = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CELL   = 3'd1,
    ST_RANGE      = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_MISALIGNED = 3'd4
  } status_t;

  localparam logic [CellBits-1:0] CellReset = CellBits'(65536);
  localparam int CfgCellSize = 0;
  localparam int CfgTolerance = 1;

  // Request: command and the four box corners in signed Q16.16.
  typedef struct packed {
    cmd_t                        command;
    logic signed [CoordBits-1:0] min_x;
    logic signed [CoordBits-1:0] min_z;
    logic signed [CoordBits-1:0] max_x;
    logic signed [CoordBits-1:0] max_z;
  } req_t;

  // Result: status and the four cell fields.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] cell_min_x;
    logic signed [31:0] cell_min_z;
    logic signed [31:0] cell_end_x;
    logic signed [31:0] cell_end_z;
  } res_t;

  typedef struct packed {
    cmd_t                command;
    logic [CellBits-1:0] csize;
    logic                empty_box;
  } tag_t;

  typedef struct packed {
    logic signed [CoordBits:0] floor_c;
    logic signed [CoordBits:0] ceil_c;
    logic signed [CoordBits:0] round_c;
    logic                      aligned;
  } lane_res_t;
endpackage

// File: design/gfq_if.sv
// Valid/ready stream interface carrying a payload of a parameter type.
interface gfq_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/grid_footprint_quantizer.sv
// Top level of the grid footprint quantizer.
// Usage: requests arrive on in_ch (command and four Q16.16 coordinates), results
// leave on out_ch (status and four cell fields), one result per request.
// Four divider lanes divide min_x, min_z, max_x and max_z by cell_size at once;
// each lane has an input register and a restoring divider with one quotient bit
// per stage (32 stages), followed by a stage that forms the rounded cells and the
// misalignment products; combinational merge logic then feeds the output register.
// A result passes through 35 register stages; throughput is one request per cycle
// while the receiver keeps up. The pipeline advances as a whole whenever
// its output register is free or being taken, so when the receiver stalls the
// whole pipeline holds and in_ch.ready falls in the same cycle.
// Configuration writes on cfg_we/cfg_index/cfg_data are captured with each
// request, so later writes never disturb queued requests.
// Reset (rst, synchronous) clears all valid bits, sets cell_size to one unit
// and tolerance to zero.
// Status codes: ok, invalid cell size, out of range, empty, misaligned; on any
// error the four cell fields are zero.
`include "grid_footprint_quantizer_defines.svh"
module grid_footprint_quantizer import gfq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [30:0] cfg_data,
  gfq_if.sink in_ch,
  gfq_if.source out_ch
);
  localparam int Depth = MagBits + 2;
  logic [CellBits-1:0] cell_size;
  logic [TolBits-1:0]  tolerance;
  logic [Depth-1:0] stage_valid;
  tag_t tags [Depth];
  logic adv;
  lane_res_t r [4];
  status_t status;
  logic signed [31:0] c0, c1, c2, c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CellReset;
      tolerance <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CfgCellSize)) cell_size <= cfg_data;
      else tolerance <= cfg_data[TolBits-1:0];
    end
  end

  // Output register frees when empty or being taken.
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      stage_valid  <= {stage_valid[Depth-2:0], in_ch.valid};
      out_ch.valid <= stage_valid[Depth-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tags[0].command   <= in_ch.payload.command;
      tags[0].csize     <= cell_size;
      tags[0].empty_box <= !($signed(in_ch.payload.max_x) > $signed(in_ch.payload.min_x)) ||
                           !($signed(in_ch.payload.max_z) > $signed(in_ch.payload.min_z));
      for (int i = 1; i < Depth; i++) tags[i] <= tags[i-1];
      out_ch.payload.status     <= status;
      out_ch.payload.cell_min_x <= c0;
      out_ch.payload.cell_min_z <= c1;
      out_ch.payload.cell_end_x <= c2;
      out_ch.payload.cell_end_z <= c3;
    end
  end

  gfq_lane u_l0 (.clk, .adv, .coord(in_ch.payload.min_x), .csize(cell_size),
                 .tol(tolerance), .res(r[0]));
  gfq_lane u_l1 (.clk, .adv, .coord(in_ch.payload.min_z), .csize(cell_size),
                 .tol(tolerance), .res(r[1]));
  gfq_lane u_l2 (.clk, .adv, .coord(in_ch.payload.max_x), .csize(cell_size),
                 .tol(tolerance), .res(r[2]));
  gfq_lane u_l3 (.clk, .adv, .coord(in_ch.payload.max_z), .csize(cell_size),
                 .tol(tolerance), .res(r[3]));

  gfq_merge u_merge (.tag(tags[Depth-1]), .l0(r[0]), .l1(r[1]), .l2(r[2]), .l3(r[3]),
                     .status, .c0, .c1, .c2, .c3);

  `GFQ_ASSERT_IMPL(a_stall_hold, clk, rst, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `GFQ_ASSERT_NEXT(a_err_zero, clk, rst, adv && stage_valid[Depth-1] && status != ST_OK, out_ch.payload.cell_min_x == '0 && out_ch.payload.cell_end_z == '0)
  `GFQ_ASSERT_IMPL(a_bad_cell, clk, rst, stage_valid[Depth-1] && tags[Depth-1].csize == '0, status == ST_BAD_CELL)
endmodule

// File: design/gfq_lane.sv
// One divider lane: pipelined restoring division of a coordinate by the cell size.
module gfq_lane import gfq_pkg::*; (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [CoordBits-1:0] coord,
  input  logic [CellBits-1:0]         csize,
  input  logic [TolBits-1:0]          tol,
  output lane_res_t                   res
);
  typedef struct packed {
    logic               neg;
    logic [MagBits-1:0] num;
    logic [CellBits:0]  rem;
    logic [CellBits-1:0] csize;
    logic [TolBits-1:0] tol;
  } st_t;

  st_t stg [MagBits+1];
  logic [CellBits+TolBits:0] dprod, tprod;
  logic [CellBits:0] d;
  logic up;
  logic [QBits:0] qr;
  logic signed [CoordBits:0] floor_q, ceil_q, round_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].neg   <= coord[CoordBits-1];
      stg[0].num   <= coord[CoordBits-1] ? MagBits'(-coord) : MagBits'(coord);
      stg[0].rem   <= '0;
      stg[0].csize <= csize;
      stg[0].tol   <= tol;
    end
  end

  for (genvar k = 0; k < MagBits; k++) begin : g_step
    logic [CellBits+1:0] trial;
    logic [CellBits+1:0] sh;
    always_comb begin
      sh    = {stg[k].rem, stg[k].num[MagBits-1]};
      trial = sh - {2'b0, stg[k].csize};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        stg[k+1].neg   <= stg[k].neg;
        stg[k+1].csize <= stg[k].csize;
        stg[k+1].tol   <= stg[k].tol;
        if (!trial[CellBits+1]) begin
          stg[k+1].rem <= trial[CellBits:0];
          stg[k+1].num <= {stg[k].num[MagBits-2:0], 1'b1};
        end else begin
          stg[k+1].rem <= sh[CellBits:0];
          stg[k+1].num <= {stg[k].num[MagBits-2:0], 1'b0};
        end
      end
    end
  end

  // Final stage: quotient sits in num, remainder in rem.
  logic [QBits:0] q, q1;
  logic rnz;
  always_comb begin
    q   = {1'b0, stg[MagBits].num};
    q1  = q + 1'b1;
    rnz = stg[MagBits].rem != '0;
    up  = {stg[MagBits].rem, 1'b0} >= {2'b0, stg[MagBits].csize};
    d   = up ? ({1'b0, stg[MagBits].csize} - stg[MagBits].rem) : stg[MagBits].rem;
    qr  = up ? q1 : q;
  end

  // Misalignment products are registered before use.
  always_ff @(posedge clk) begin
    if (adv) begin
      dprod   <= {1'b0, d, 16'b0};
      tprod   <= (CellBits+TolBits+1)'(stg[MagBits].tol) *
                 (CellBits+TolBits+1)'(stg[MagBits].csize);
      floor_q <= stg[MagBits].neg ? -$signed((rnz ? q1 : q)) : $signed(q);
      ceil_q  <= stg[MagBits].neg ? -$signed(q) : $signed(rnz ? q1 : q);
      round_q <= stg[MagBits].neg ? -$signed(qr) : $signed(qr);
    end
  end
  assign res = '{floor_c: floor_q, ceil_c: ceil_q, round_c: round_q,
                 aligned: !(dprod > tprod)};
endmodule

// File: design/gfq_merge.sv
// Merges the four lane results into status and cell fields.
module gfq_merge import gfq_pkg::*; (
  input  tag_t      tag,
  input  lane_res_t l0, l1, l2, l3,
  output status_t   status,
  output logic signed [31:0] c0, c1, c2, c3
);
  function automatic logic fits(input logic signed [CoordBits:0] v);
    return v >= -(CoordBits+1)'(64'sd2147483648) && v <= (CoordBits+1)'(64'sd2147483647);
  endfunction
  logic signed [CoordBits:0] a0, a1, a2, a3;
  status_t st;
  always_comb begin
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    st = ST_OK;
    if (tag.csize == '0) st = ST_BAD_CELL;
    else if (tag.command == CMD_POINT || tag.command == CMD_SPARE) begin
      a0 = l0.floor_c; a1 = l1.floor_c;
      if (!fits(a0) || !fits(a1)) st = ST_RANGE;
    end else if (tag.empty_box) st = ST_EMPTY;
    else if (tag.command == CMD_CONTAIN) begin
      a0 = l0.floor_c; a1 = l1.floor_c; a2 = l2.ceil_c; a3 = l3.ceil_c;
      if (!fits(a0) || !fits(a1) || !fits(a2) || !fits(a3)) st = ST_RANGE;
      else if (a2 <= a0 || a3 <= a1) st = ST_EMPTY;
    end else begin
      a0 = l0.round_c; a1 = l1.round_c; a2 = l2.round_c; a3 = l3.round_c;
      if (!l0.aligned || !fits(a0) || !l1.aligned || !fits(a1) ||
          !l2.aligned || !fits(a2) || !l3.aligned || !fits(a3)) st = ST_MISALIGNED;
      else if (a2 <= a0 || a3 <= a1) st = ST_EMPTY;
    end
    status = st;
    c0 = (st == ST_OK) ? a0[31:0] : '0;
    c1 = (st == ST_OK) ? a1[31:0] : '0;
    c2 = (st == ST_OK) ? a2[31:0] : '0;
    c3 = (st == ST_OK) ? a3[31:0] : '0;
  end
endmodule

// File: dv/tb_grid_footprint_quantizer.sv
// Self-checking testbench of the grid footprint quantizer, with its own predictor.
module tb_grid_footprint_quantizer import gfq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The four box corners of a request; the command travels beside them in the request.
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_z;
  } corners_t;

  // One row of the directed table. Where known is set, the result is typed in by hand.
  // Every other row is checked against the predictor.
  typedef struct {
    cmd_t     cmd;
    corners_t box;
    bit       known;
    res_t     res;
  } row_t;

  localparam int Settle = 40;
  localparam longint IMin = -64'sd2147483648;
  localparam longint IMax = 64'sd2147483647;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [30:0] cfg_data;

  gfq_if #(.payload_t(req_t)) req_ch (clk);
  gfq_if #(.payload_t(res_t)) res_ch (clk);

  grid_footprint_quantizer dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(req_ch.sink), .out_ch(res_ch.source)
  );

  // This is the testbench's own copy of the block's two registers.
  longint cell_len;
  longint tol_frac;

  res_t   pending_cells[$];
  int     errors;
  bit     quiet;      // The last phase runs with no idling on either side.
  bit     hold_res;   // The sender asks for one long stall of the receiver.

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up after a fixed time, well beyond the slowest correct run.
  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

  function automatic bit fits_i32(longint v);
    return v >= IMin && v <= IMax;
  endfunction

  // Divide |v| by c and return the quotient and remainder of the magnitudes.
  function automatic void div_mag(longint v, longint c, output longint q, output longint r);
    longint m;
    m = v < 0 ? -v : v;
    q = m / c;
    r = m % c;
  endfunction

  function automatic longint floor_cell(longint v, longint c);
    longint q, r;
    div_mag(v, c, q, r);
    return v >= 0 ? q : -(q + (r != 0));
  endfunction

  function automatic longint ceil_cell(longint v, longint c);
    longint q, r;
    div_mag(v, c, q, r);
    return v >= 0 ? q + (r != 0) : -q;
  endfunction

  // Round half away from zero. A miss means the edge is misaligned or the rounded cell does not fit.
  function automatic bit round_cell(longint v, longint c, longint tol, output longint idx);
    longint q, r, d;
    div_mag(v, c, q, r);
    if (2 * r >= c) begin
      q = q + 1;
      d = c - r;
    end else begin
      d = r;
    end
    idx = v < 0 ? -q : q;
    if (d * 65536 > tol * c) return 1'b0;
    return fits_i32(idx);
  endfunction

  function automatic res_t quantize(cmd_t cmd, corners_t b);
    longint lo_x, lo_z, hi_x, hi_z;
    longint c0, c1, c2, c3;
    res_t o;
    status_t st;
    lo_x = b.min_x;
    lo_z = b.min_z;
    hi_x = b.max_x;
    hi_z = b.max_z;
    c0 = 0; c1 = 0; c2 = 0; c3 = 0;
    st = ST_OK;
    if (cell_len == 0) begin
      st = ST_BAD_CELL;
    end else if (cmd == CMD_POINT || cmd == CMD_SPARE) begin
      // The spare command is decoded as a point.
      c0 = floor_cell(lo_x, cell_len);
      c1 = floor_cell(lo_z, cell_len);
      if (!fits_i32(c0) || !fits_i32(c1)) st = ST_RANGE;
    end else if (!(hi_x > lo_x) || !(hi_z > lo_z)) begin
      st = ST_EMPTY;
    end else if (cmd == CMD_CONTAIN) begin
      c0 = floor_cell(lo_x, cell_len);
      c1 = floor_cell(lo_z, cell_len);
      c2 = ceil_cell(hi_x, cell_len);
      c3 = ceil_cell(hi_z, cell_len);
      if (!fits_i32(c0) || !fits_i32(c1) || !fits_i32(c2) || !fits_i32(c3)) st = ST_RANGE;
      else if (c2 <= c0 || c3 <= c1) st = ST_EMPTY;
    end else begin
      if (!round_cell(lo_x, cell_len, tol_frac, c0) || !round_cell(lo_z, cell_len, tol_frac, c1)
          || !round_cell(hi_x, cell_len, tol_frac, c2)
          || !round_cell(hi_z, cell_len, tol_frac, c3)) st = ST_MISALIGNED;
      else if (c2 <= c0 || c3 <= c1) st = ST_EMPTY;
    end
    o.status = st;
    o.cell_min_x = st == ST_OK ? c0[31:0] : '0;
    o.cell_min_z = st == ST_OK ? c1[31:0] : '0;
    o.cell_end_x = st == ST_OK ? c2[31:0] : '0;
    o.cell_end_z = st == ST_OK ? c3[31:0] : '0;
    return o;
  endfunction

  // Coordinates are drawn near cell boundaries, halfway points, extremes, near zero and anywhere at all.
  function automatic logic [31:0] pick_coord();
    longint lim, k, v, c;
    c = cell_len == 0 ? 65536 : cell_len;
    lim = 64'sd2147483647 / c;
    k = longint'($urandom_range(0, 2 * lim)) - lim;
    case ($urandom_range(0, 6))
      0: begin
        case ($urandom_range(0, 3))
          0: v = IMin;
          1: v = IMax;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1: v = $signed($urandom());
      2: v = longint'($urandom_range(0, 32'h80000)) - 32'h40000;
      3: v = k * c + longint'($urandom_range(0, 64)) - 32;
      4: v = k * c + c / 2 - longint'($urandom_range(0, 1));
      default: v = k * c;
    endcase
    return v[31:0];
  endfunction

  function automatic corners_t pick_box();
    corners_t b;
    logic signed [31:0] a, t;
    b.min_x = pick_coord();
    b.min_z = pick_coord();
    b.max_x = pick_coord();
    b.max_z = pick_coord();
    // Most boxes are well formed, so that they reach the division and the alignment checks.
    if ($urandom_range(0, 9) < 8) begin
      if (b.min_x > b.max_x) begin a = b.min_x; b.min_x = b.max_x; b.max_x = a; end
      if (b.min_z > b.max_z) begin t = b.min_z; b.min_z = b.max_z; b.max_z = t; end
    end
    return b;
  endfunction

  // The caller drops the write enable after its last write.
  task automatic write_reg(int idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data <= val[30:0];
    @(posedge clk);
    if (idx == CfgCellSize) cell_len = val & 64'h7FFFFFFF;
    else tol_frac = val & 64'h1FFFF;
  endtask

  // Hold off until every expected result has come, and then let the pipeline drain.
  task automatic drain();
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  // Offer one request and keep it up until the block takes it.
  // Then record the expected result.
  task automatic send(cmd_t cmd, corners_t b, bit known, res_t res);
    int gap;
    req_t q;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q.command = cmd;
    q.min_x = b.min_x;
    q.min_z = b.min_z;
    q.max_x = b.max_x;
    q.max_z = b.max_z;
    req_ch.valid <= 1'b1;
    req_ch.payload <= q;
    do @(posedge clk); while (!req_ch.ready);
    pending_cells.push_back(known ? res : quantize(cmd, b));
  endtask

  function automatic res_t ok_cells(int a, int b, int c, int d);
    res_t o;
    o.status = ST_OK;
    o.cell_min_x = a;
    o.cell_min_z = b;
    o.cell_end_x = c;
    o.cell_end_z = d;
    return o;
  endfunction

  function automatic res_t err_cells(status_t st);
    res_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

  // The receiver stalls in random bursts. On request it also takes one long stall, counted here.
  initial begin
    int n;
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_res) begin
        res_ch.ready <= 1'b0;
        for (n = 0; n < 150; n++) @(posedge clk);
        hold_res = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Each result taken is compared, field by field, with the oldest expectation.
  always @(posedge clk) begin
    res_t want, got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (pending_cells.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, got);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %s got %0d", $time, want.status.name(), got.status);
          errors++;
        end
        if (got.cell_min_x !== want.cell_min_x) begin
          $display("%0t: cell_min_x expected %0d got %0d", $time, want.cell_min_x,
                   got.cell_min_x);
          errors++;
        end
        if (got.cell_min_z !== want.cell_min_z) begin
          $display("%0t: cell_min_z expected %0d got %0d", $time, want.cell_min_z,
                   got.cell_min_z);
          errors++;
        end
        if (got.cell_end_x !== want.cell_end_x) begin
          $display("%0t: cell_end_x expected %0d got %0d", $time, want.cell_end_x,
                   got.cell_end_x);
          errors++;
        end
        if (got.cell_end_z !== want.cell_end_z) begin
          $display("%0t: cell_end_z expected %0d got %0d", $time, want.cell_end_z,
                   got.cell_end_z);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    longint phase_cell[7];
    longint phase_tol[7];
    int p, i;
    cmd_t cmd;

    errors = 0;
    quiet = 1'b0;
    hold_res = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cell_len = 65536;
    tol_frac = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows run with the reset settings: a cell of one unit and zero tolerance.
    r = '{CMD_POINT, '{0, 0, 0, 0}, 1, ok_cells(0, 0, 0, 0)};
    rows.push_back(r);
    r = '{CMD_POINT, '{-1, -1, 0, 0}, 1, ok_cells(-1, -1, 0, 0)};
    rows.push_back(r);
    r = '{CMD_POINT, '{32'h80000000, 32'h7FFFFFFF, 5, 9}, 1, ok_cells(-32768, 32767, 0, 0)};
    rows.push_back(r);
    r = '{CMD_CONTAIN, '{0, 0, 65536, 65536}, 1, ok_cells(0, 0, 1, 1)};
    rows.push_back(r);
    r = '{CMD_CONTAIN, '{1, 1, 2, 2}, 1, ok_cells(0, 0, 1, 1)};
    rows.push_back(r);
    r = '{CMD_CONTAIN, '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1,
          ok_cells(-32768, -32768, 32768, 32768)};
    rows.push_back(r);
    // A box with no width, and a box turned inside out, are both empty.
    r = '{CMD_CONTAIN, '{5, 5, 5, 9}, 1, err_cells(ST_EMPTY)};
    rows.push_back(r);
    r = '{CMD_ALIGN, '{100, 9, 200, 3}, 1, err_cells(ST_EMPTY)};
    rows.push_back(r);
    r = '{CMD_ALIGN, '{0, 0, 131072, 65536}, 1, ok_cells(0, 0, 2, 1)};
    rows.push_back(r);
    r = '{CMD_ALIGN, '{1, 0, 65536, 65536}, 1, err_cells(ST_MISALIGNED)};
    rows.push_back(r);
    r = '{CMD_ALIGN, '{32768, 0, 98304, 65536}, 1, err_cells(ST_MISALIGNED)};
    rows.push_back(r);
    r = '{CMD_ALIGN, '{-131072, -65536, 32'h7FFF0000, 0}, 0, '0};
    rows.push_back(r);
    r = '{CMD_SPARE, '{327680, -98305, 7, 7}, 0, '0};
    rows.push_back(r);
    r = '{CMD_CONTAIN, '{-65537, -65536, -1, 0}, 0, '0};
    rows.push_back(r);
    r = '{CMD_POINT, '{32'h5A5A5A5A, 32'hA5A5A5A5, 32'hFFFFFFFF, 32'h80000000}, 0, '0};
    rows.push_back(r);
    foreach (rows[k]) send(rows[k].cmd, rows[k].box, rows[k].known, rows[k].res);
    req_ch.valid <= 1'b0;
    drain();

    // The phases cover the smallest cell, the largest cell, an invalid zero cell,
    // a full cell of tolerance, and a tolerance above one cell.
    phase_cell = '{1, 32'h7FFFFFFF, 0, 3 * 65536, 1000, 65536 + 4321, 65536};
    phase_tol = '{0, 65536, 12345, 32768, 131071, 1, 0};
    for (p = 0; p < 7; p++) begin
      write_reg(CfgCellSize, phase_cell[p]);
      write_reg(CfgTolerance, phase_tol[p]);
      cfg_we <= 1'b0;
      quiet = p == 6;
      for (i = 0; i < 205; i++) begin
        // A long stall of the receiver fills the pipeline while requests keep coming.
        if (p == 3 && i == 50) hold_res = 1'b1;
        // The sender waits once until every result is back.
        if (p == 4 && i == 100) begin
          req_ch.valid <= 1'b0;
          drain();
        end
        cmd = cmd_t'($urandom_range(0, 3));
        send(cmd, pick_box(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
